@@ sv/ssb_pkg.sv @@
package ssb_pkg;

   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int PITCH_BITS      = 12;
   localparam int SRC_WIDTH_BITS  = 12;
   localparam int PIXEL_BITS      = 16;
   localparam int RECT_BITS       = 12;
   localparam int FIX_BITS        = 32;
   localparam int FLOOR_BITS      = 16;
   localparam int DEST_FIELD_BITS = 24;
   localparam int QUO_BITS        = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_PITCH      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSPARENT_KEY = 2'd2;

   localparam logic [PITCH_BITS-1:0]     RESET_DEST_PITCH = 12'd640;
   localparam logic [SRC_WIDTH_BITS-1:0] RESET_SRC_WIDTH  = 12'd256;
   localparam logic [PIXEL_BITS-1:0]     RESET_KEY        = 16'd0;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_ADVANCE = 2'd2;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [15:0]                 src_index;
      logic [PIXEL_BITS-1:0]       src_pixel;
      logic [RECT_BITS-1:0]        left;
      logic [RECT_BITS-1:0]        top;
      logic [RECT_BITS-1:0]        right;
      logic [RECT_BITS-1:0]        bottom;
      logic signed [FIX_BITS-1:0]  u_start;
      logic signed [FIX_BITS-1:0]  v_start;
      logic signed [FIX_BITS-1:0]  u_end;
      logic signed [FIX_BITS-1:0]  v_end;
   } req_type;

   typedef struct packed {
      logic [DEST_FIELD_BITS-1:0] dest_addr;
      logic [PIXEL_BITS-1:0]      out_pixel;
      logic                       write_enable;
      logic                       last;
      logic                       idle;
   } rsp_type;

   typedef struct packed {
      logic                       start;
      logic signed [QUO_BITS:0]   diff;
   } div_cmd_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic [QUO_BITS-1:0]        quo;
   } div_res_type;

endpackage

@@ sv/ssb_div.sv @@
module ssb_div
   import ssb_pkg::*;
#(
   parameter int DEN_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  div_cmd_type         cmd,
   input  logic [DEN_BITS-1:0] den,
   output div_res_type         res
);

   localparam int STEP_BITS = $clog2(QUO_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic [QUO_BITS-1:0]   mag_ff, mag_in;
   logic [DEN_BITS-1:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;

   logic [DEN_BITS:0]     trial;
   logic [DEN_BITS:0]     trial_sub;
   logic                  take;
   logic [QUO_BITS-1:0]   mag_step;
   logic [QUO_BITS:0]     abs_diff;

   always_comb begin
      trial     = {rem_ff, mag_ff[QUO_BITS-1]};
      trial_sub = trial - {1'b0, den_ff};
      take      = trial >= {1'b0, den_ff};
      mag_step  = {mag_ff[QUO_BITS-2:0], take};
      abs_diff  = cmd.diff[QUO_BITS] ? -cmd.diff : cmd.diff;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mag_in  = abs_diff[QUO_BITS-1:0];
         rem_in  = '0;
         den_in  = den;
         neg_in  = cmd.diff[QUO_BITS];
      end else if (busy_ff) begin
         mag_in = mag_step;
         rem_in = take ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         cnt_in = cnt_ff + STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(QUO_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? -mag_step : mag_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign res.busy = busy_ff;
   assign res.done = done_ff;
   assign res.quo  = quo_ff;

endmodule

@@ sv/scaled_sprite_blit_color_key_core.sv @@
// Load: texel index reduction pipeline, then one store write.
// Advance, draw active: index multiply, offset add, reciprocal modulo in two stages,
// store read; the next request is accepted only once the response has been pushed.
// Advance, no draw: an idle response. Start: two 32-step radix-2 divides on one divider.
// Reset: config registers to 640 / 256 / 0, no draw active, rsp channel empty;
// the source store is not cleared.
module scaled_sprite_blit_color_key_core
   import ssb_pkg::*;
#(
   parameter int SRC_WORDS      = 65536,
   parameter int DEST_ADDR_BITS = 24,
   parameter int COORD_BITS     = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS   = $clog2(SRC_WORDS);
   localparam int CB         = COORD_BITS + 1;
   localparam int PROD_BITS  = FLOOR_BITS + SRC_WIDTH_BITS + 1;
   localparam int X_BITS     = PROD_BITS + 1;
   localparam int RECIP_BITS = X_BITS - IDX_BITS + 1;
   localparam int QM_BITS    = X_BITS + RECIP_BITS;
   localparam int PTL_BITS   = PITCH_BITS + COORD_BITS + 1;

   localparam logic [63:0] WORDS_W    = 64'(SRC_WORDS);
   localparam logic [63:0] MOD_OFFSET =
      ((64'd1 << (PROD_BITS - 1)) + WORDS_W - 64'd1) / WORDS_W * WORDS_W;
   localparam logic [RECIP_BITS-1:0] RECIP_K  = RECIP_BITS'((64'd1 << X_BITS) / WORDS_W);
   localparam logic [X_BITS-1:0]     WORDS_X  = X_BITS'(SRC_WORDS);
   localparam logic [IDX_BITS:0]     WORDS_R  = (IDX_BITS + 1)'(SRC_WORDS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_SUM    = 4'd2;
   localparam logic [3:0] ST_RECIP  = 4'd3;
   localparam logic [3:0] ST_REDUCE = 4'd4;
   localparam logic [3:0] ST_FIX    = 4'd5;
   localparam logic [3:0] ST_PUSH   = 4'd6;
   localparam logic [3:0] ST_DIV_U  = 4'd7;
   localparam logic [3:0] ST_DIV_V  = 4'd8;

   // control
   logic [3:0]                state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      draw_active_ff, draw_active_in;
   logic                      div_go_ff, div_go_in;
   logic [PITCH_BITS-1:0]     dest_pitch_ff, dest_pitch_in;
   logic [SRC_WIDTH_BITS-1:0] src_width_ff, src_width_in;
   logic [PIXEL_BITS-1:0]     key_ff, key_in;

   // draw state
   logic [FIX_BITS-1:0]       step_u_ff, step_u_in;
   logic [FIX_BITS-1:0]       step_v_ff, step_v_in;
   logic [FIX_BITS-1:0]       cur_u_ff, cur_u_in;
   logic [FIX_BITS-1:0]       cur_v_ff, cur_v_in;
   logic [FIX_BITS-1:0]       row_u_ff, row_u_in;
   logic [CB-1:0]             col_count_ff, col_count_in;
   logic [CB-1:0]             rows_left_ff, rows_left_in;
   logic [CB-1:0]             span_ff, span_in;
   logic [DEST_ADDR_BITS-1:0] cur_dest_ff, cur_dest_in;

   // request datapath
   logic                      op_load_ff, op_load_in;
   logic [15:0]               load_idx_ff, load_idx_in;
   logic [PIXEL_BITS-1:0]     load_pix_ff, load_pix_in;
   logic signed [FLOOR_BITS-1:0] fv_ff, fv_in;
   logic signed [FLOOR_BITS-1:0] fu_ff, fu_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [X_BITS-1:0]         x_ff, x_in;
   logic [QM_BITS-1:0]        qm_ff, qm_in;
   logic [IDX_BITS:0]         rp_ff, rp_in;
   logic signed [QUO_BITS:0]  du_ff, du_in;
   logic signed [QUO_BITS:0]  dv_ff, dv_in;
   logic [DEST_ADDR_BITS-1:0] pend_dest_ff, pend_dest_in;
   logic                      pend_last_ff, pend_last_in;
   logic                      pend_idle_ff, pend_idle_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // source store
   logic [PIXEL_BITS-1:0]     src_mem [SRC_WORDS];
   logic [PIXEL_BITS-1:0]     rd_data_ff;
   logic                      mem_we;
   logic                      mem_re;
   logic [IDX_BITS-1:0]       mem_addr;

   // helpers
   logic                      req_fire;
   logic                      push_ok;
   logic [COORD_BITS-1:0]     l_c, t_c, r_c, b_c;
   logic                      extent_ok;
   logic [PTL_BITS-1:0]       ptl;
   logic [CB-1:0]             col_next;
   logic                      row_end;
   logic [CB-1:0]             rows_next;
   logic [X_BITS-1:0]         q_ext;
   logic [X_BITS-1:0]         rp_full;
   logic [IDX_BITS:0]         idx_fixed;
   logic [PIXEL_BITS-1:0]     pix;
   logic [DEST_ADDR_BITS+DEST_FIELD_BITS-1:0] dest_wide;

   div_cmd_type               div_cmd;
   div_res_type               div_res;
   logic [COORD_BITS-1:0]     div_den;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign push_ok   = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign div_cmd.start = div_go_ff;
   assign div_cmd.diff  = (state_ff == ST_DIV_U) ? du_ff : dv_ff;
   assign div_den       = (state_ff == ST_DIV_U) ? span_ff[COORD_BITS-1:0]
                                                 : rows_left_ff[COORD_BITS-1:0];

   ssb_div #(
      .DEN_BITS (COORD_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .den   (div_den),
      .res   (div_res)
   );

   always_comb begin
      l_c       = COORD_BITS'(req_data.left);
      t_c       = COORD_BITS'(req_data.top);
      r_c       = COORD_BITS'(req_data.right);
      b_c       = COORD_BITS'(req_data.bottom);
      extent_ok = (r_c > l_c) && (b_c > t_c);
      ptl       = PTL_BITS'(dest_pitch_ff) * PTL_BITS'(t_c) + PTL_BITS'(l_c);

      col_next  = col_count_ff + CB'(1);
      row_end   = col_next >= span_ff;
      rows_next = (rows_left_ff != '0) ? rows_left_ff - CB'(1) : '0;

      q_ext     = X_BITS'(qm_ff[QM_BITS-1:X_BITS]);
      rp_full   = x_ff - q_ext * WORDS_X;
      idx_fixed = (rp_ff >= WORDS_R) ? rp_ff - WORDS_R : rp_ff;

      pix       = pend_idle_ff ? '0 : rd_data_ff;
      dest_wide = {{DEST_FIELD_BITS{1'b0}}, pend_dest_ff};

      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      draw_active_in = draw_active_ff;
      div_go_in      = 1'b0;
      step_u_in      = step_u_ff;
      step_v_in      = step_v_ff;
      cur_u_in       = cur_u_ff;
      cur_v_in       = cur_v_ff;
      row_u_in       = row_u_ff;
      col_count_in   = col_count_ff;
      rows_left_in   = rows_left_ff;
      span_in        = span_ff;
      cur_dest_in    = cur_dest_ff;
      op_load_in     = op_load_ff;
      load_idx_in    = load_idx_ff;
      load_pix_in    = load_pix_ff;
      fv_in          = fv_ff;
      fu_in          = fu_ff;
      prod_in        = prod_ff;
      x_in           = x_ff;
      qm_in          = qm_ff;
      rp_in          = rp_ff;
      du_in          = du_ff;
      dv_in          = dv_ff;
      pend_dest_in   = pend_dest_ff;
      pend_last_in   = pend_last_ff;
      pend_idle_in   = pend_idle_ff;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = idx_fixed[IDX_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.kind)
                  KIND_LOAD: begin
                     op_load_in  = 1'b1;
                     load_idx_in = req_data.src_index;
                     load_pix_in = req_data.src_pixel;
                     state_in    = ST_SUM;
                  end
                  KIND_START: begin
                     if (extent_ok) begin
                        du_in = {req_data.u_end[FIX_BITS-1], req_data.u_end}
                              - {req_data.u_start[FIX_BITS-1], req_data.u_start};
                        dv_in = {req_data.v_end[FIX_BITS-1], req_data.v_end}
                              - {req_data.v_start[FIX_BITS-1], req_data.v_start};
                        cur_u_in       = req_data.u_start;
                        row_u_in       = req_data.u_start;
                        cur_v_in       = req_data.v_start;
                        span_in        = CB'(r_c) - CB'(l_c);
                        rows_left_in   = CB'(b_c) - CB'(t_c);
                        col_count_in   = '0;
                        cur_dest_in    = DEST_ADDR_BITS'(ptl);
                        draw_active_in = 1'b1;
                        div_go_in      = 1'b1;
                        state_in       = ST_DIV_U;
                     end else begin
                        draw_active_in = 1'b0;
                     end
                  end
                  KIND_ADVANCE: begin
                     if (draw_active_ff) begin
                        op_load_in   = 1'b0;
                        fv_in        = cur_v_ff[FIX_BITS-1:FIX_BITS-FLOOR_BITS];
                        fu_in        = cur_u_ff[FIX_BITS-1:FIX_BITS-FLOOR_BITS];
                        pend_dest_in = cur_dest_ff;
                        pend_idle_in = 1'b0;
                        pend_last_in = 1'b0;
                        if (row_end) begin
                           col_count_in = '0;
                           cur_u_in     = row_u_ff;
                           cur_v_in     = cur_v_ff + step_v_ff;
                           cur_dest_in  = cur_dest_ff + DEST_ADDR_BITS'(1)
                                        + DEST_ADDR_BITS'(dest_pitch_ff)
                                        - DEST_ADDR_BITS'(span_ff);
                           rows_left_in = rows_next;
                           if (rows_next == '0) begin
                              pend_last_in   = 1'b1;
                              draw_active_in = 1'b0;
                           end
                        end else begin
                           col_count_in = col_next;
                           cur_u_in     = cur_u_ff + step_u_ff;
                           cur_dest_in  = cur_dest_ff + DEST_ADDR_BITS'(1);
                        end
                        state_in = ST_MUL;
                     end else begin
                        pend_dest_in = '0;
                        pend_idle_in = 1'b1;
                        pend_last_in = 1'b0;
                        state_in     = ST_PUSH;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(fv_ff) * PROD_BITS'($signed({1'b0, src_width_ff}));
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (op_load_ff) begin
               x_in = X_BITS'(load_idx_ff);
            end else begin
               x_in = {{(X_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff}
                    + {{(X_BITS-FLOOR_BITS){fu_ff[FLOOR_BITS-1]}}, fu_ff}
                    + X_BITS'(MOD_OFFSET);
            end
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            qm_in    = QM_BITS'(x_ff) * QM_BITS'(RECIP_K);
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            rp_in    = rp_full[IDX_BITS:0];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (op_load_ff) begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ok) begin
               rsp_data_in.dest_addr    = dest_wide[DEST_FIELD_BITS-1:0];
               rsp_data_in.out_pixel    = pix;
               rsp_data_in.write_enable = !pend_idle_ff && (pix != key_ff);
               rsp_data_in.last         = pend_last_ff;
               rsp_data_in.idle         = pend_idle_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         ST_DIV_U: begin
            if (div_res.done) begin
               step_u_in = div_res.quo;
               div_go_in = 1'b1;
               state_in  = ST_DIV_V;
            end
         end
         ST_DIV_V: begin
            if (div_res.done) begin
               step_v_in = div_res.quo;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      dest_pitch_in = dest_pitch_ff;
      src_width_in  = src_width_ff;
      key_in        = key_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEST_PITCH:      dest_pitch_in = csr_wdata[PITCH_BITS-1:0];
            CSR_SRC_WIDTH:       src_width_in  = csr_wdata[SRC_WIDTH_BITS-1:0];
            CSR_TRANSPARENT_KEY: key_in        = csr_wdata[PIXEL_BITS-1:0];
            default:             key_in        = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         draw_active_ff <= 1'b0;
         div_go_ff      <= 1'b0;
         dest_pitch_ff  <= RESET_DEST_PITCH;
         src_width_ff   <= RESET_SRC_WIDTH;
         key_ff         <= RESET_KEY;
         step_u_ff      <= '0;
         step_v_ff      <= '0;
         cur_u_ff       <= '0;
         cur_v_ff       <= '0;
         row_u_ff       <= '0;
         col_count_ff   <= '0;
         rows_left_ff   <= '0;
         span_ff        <= '0;
         cur_dest_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         draw_active_ff <= draw_active_in;
         div_go_ff      <= div_go_in;
         dest_pitch_ff  <= dest_pitch_in;
         src_width_ff   <= src_width_in;
         key_ff         <= key_in;
         step_u_ff      <= step_u_in;
         step_v_ff      <= step_v_in;
         cur_u_ff       <= cur_u_in;
         cur_v_ff       <= cur_v_in;
         row_u_ff       <= row_u_in;
         col_count_ff   <= col_count_in;
         rows_left_ff   <= rows_left_in;
         span_ff        <= span_in;
         cur_dest_ff    <= cur_dest_in;
      end
      op_load_ff   <= op_load_in;
      load_idx_ff  <= load_idx_in;
      load_pix_ff  <= load_pix_in;
      fv_ff        <= fv_in;
      fu_ff        <= fu_in;
      prod_ff      <= prod_in;
      x_ff         <= x_in;
      qm_ff        <= qm_in;
      rp_ff        <= rp_in;
      du_ff        <= du_in;
      dv_ff        <= dv_in;
      pend_dest_ff <= pend_dest_in;
      pend_last_ff <= pend_last_in;
      pend_idle_ff <= pend_idle_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         src_mem[mem_addr] <= load_pix_ff;
      end
      if (mem_re) begin
         rd_data_ff <= src_mem[mem_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_res.busy)
      else $error("divider busy while taking requests");

   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.idle) |->
         (!rsp_data.write_enable && !rsp_data.last && rsp_data.out_pixel == '0))
      else $error("idle response carries data");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && push_ok && pend_last_ff) |=> !draw_active_ff)
      else $error("draw still active after last pixel");

endmodule
